>>> sv/running_and_window_average_core_defines.svh
// ----------------------------------------------------------------------------
// running_and_window_average_core_defines
// Assertion macros shared by the running and window average core.
// ----------------------------------------------------------------------------
`ifndef RUNNING_AND_WINDOW_AVERAGE_CORE_DEFINES_SVH
`define RUNNING_AND_WINDOW_AVERAGE_CORE_DEFINES_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low.
`define RAVG_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off while rst_n is low.
`define RAVG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/ravg_pkg.sv
// ----------------------------------------------------------------------------
// ravg_pkg
// Widths and controller/datapath interface types of the average core.
// ----------------------------------------------------------------------------
`default_nettype none

package ravg_pkg;

  localparam int SAMPLE_W = 16;          // Q8.8 sample and mean width
  localparam int CNT_W    = 10;          // sample count and divisor width
  localparam int SUM_W    = 26;          // running sum width
  localparam int QUO_W    = SAMPLE_W;    // quotient magnitude bits
  localparam int STEP_W   = $clog2(QUO_W);

  // Commands from the controller to the datapath
  typedef struct packed {
    logic take;      // transaction accepted: update count, sum, window
    logic div_go;    // start the running sum / count division
    logic ovr_zero;  // clear both means (no samples stored)
    logic ovr_load;  // load overall mean from the divider
    logic rec_copy;  // load recent mean from the same quotient
    logic rec_load;  // load recent mean from the window reciprocal product
    logic out_load;  // move the result into the output register
  } ravg_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic cnt_zero;   // no samples stored
    logic below_win;  // fewer than WINDOW samples stored
    logic div_done;   // quotient ready
    logic out_free;   // output register can take a result
  } ravg_sts_t;

endpackage

`default_nettype wire

>>> sv/running_and_window_average_core.sv
// ----------------------------------------------------------------------------
// running_and_window_average_core
// The overall mean is the running sum over count from the 16-step
//   divider; the window mean is a constant reciprocal product that settles
//   while that division runs. A ready result waits while the previous one is
//   still held by out_stall, and no new sample is taken until it has moved
//   into the output register.
// Reset (rst_n low, synchronous): count, sum and window clear to zero, no
//   result is pending and the core is ready for a new sample.
// ----------------------------------------------------------------------------
`default_nettype none

module running_and_window_average_core
  import ravg_pkg::*;
#(
  parameter int CAPACITY = 512,  // samples stored before rejecting (5..1023)
  parameter int WINDOW   = 5     // length of the recent-sample window (2..16)
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // input channel: one Q8.8 temperature per transaction
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic signed [SAMPLE_W-1:0]  in_sample,
  // result channel: one transaction per input transaction
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             out_accepted,
  output logic        [CNT_W-1:0]          out_sample_total,
  output logic signed [SAMPLE_W-1:0]       out_overall_mean,
  output logic signed [SAMPLE_W-1:0]       out_recent_mean
);

  // The controller walks each transaction through: update state on accept,
  // divide running sum by count, load the window mean from its reciprocal
  // product (or copy the overall mean while the window is still filling),
  // and finally park the result in the output register.
  // A new sample is taken while the previous result still waits there.
  ravg_cmd_t cmd;
  ravg_sts_t sts;

  ravg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds the count, running sum, window ring with its
  // running window sum, the divider, the reciprocal product and the
  // output register.
  ravg_dp #(
    .CAPACITY (CAPACITY),
    .WINDOW   (WINDOW)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_sample        (in_sample),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_accepted     (out_accepted),
    .out_sample_total (out_sample_total),
    .out_overall_mean (out_overall_mean),
    .out_recent_mean  (out_recent_mean)
  );

endmodule

`default_nettype wire

>>> sv/ravg_div.sv
// ----------------------------------------------------------------------------
// ravg_div
// Restoring signed divider, one quotient bit per cycle, truncating to zero.
// ----------------------------------------------------------------------------
`default_nettype none
`include "running_and_window_average_core_defines.svh"

module ravg_div
  import ravg_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      go,
  input  wire logic signed [SUM_W-1:0]   dividend,
  input  wire logic        [CNT_W-1:0]   divisor,
  output logic                           done,
  output logic signed [QUO_W-1:0]        quotient
);

  // The quotient magnitude always fits QUO_W bits (a mean of samples), so
  // the upper dividend bits start out below the divisor.
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic              neg_r, neg_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [CNT_W-1:0]  dvs_r, dvs_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [QUO_W-1:0]  quo_r, quo_nxt;

  logic [SUM_W-1:0]  mag;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    diff;
  logic              fits;

  assign mag   = dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
  assign trial = {rem_r, quo_r[QUO_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign fits  = (trial >= {1'b0, dvs_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    neg_nxt  = neg_r;
    step_nxt = step_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (go) begin
      busy_nxt = 1'b1;
      neg_nxt  = dividend[SUM_W-1];
      step_nxt = STEP_W'(QUO_W - 1);
      dvs_nxt  = divisor;
      rem_nxt  = mag[SUM_W-1 -: CNT_W];
      quo_nxt  = mag[QUO_W-1:0];
    end else if (busy_r) begin
      rem_nxt = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      quo_nxt = {quo_r[QUO_W-2:0], fits};
      if (step_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        step_nxt = step_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    neg_r  <= neg_nxt;
    step_r <= step_nxt;
    dvs_r  <= dvs_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = neg_r ? $signed(~quo_r + 1'b1) : $signed(quo_r);

  `RAVG_ASSERT_SAME(a_done_idle, done_r, !busy_r, "divider done while still busy")
  `RAVG_ASSERT_NEXT(a_go_busy, go, busy_r, "divider did not start on go")

endmodule

`default_nettype wire

>>> sv/ravg_dp.sv
// ----------------------------------------------------------------------------
// ravg_dp
// Count, running sum, sample window, divider and output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "running_and_window_average_core_defines.svh"

module ravg_dp
  import ravg_pkg::*;
#(
  parameter int CAPACITY = 512,
  parameter int WINDOW   = 5
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire ravg_cmd_t                   cmd,
  output ravg_sts_t                        sts,
  input  wire logic signed [SAMPLE_W-1:0]  in_sample,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             out_accepted,
  output logic        [CNT_W-1:0]          out_sample_total,
  output logic signed [SAMPLE_W-1:0]       out_overall_mean,
  output logic signed [SAMPLE_W-1:0]       out_recent_mean
);

  localparam int PTR_W  = $clog2(WINDOW);
  localparam int WSUM_W = SAMPLE_W + $clog2(WINDOW);
  // Window mean by reciprocal: floor(n * RCP_M / 2^RCP_K) equals
  // floor(n / WINDOW) for every magnitude n below 2^WSUM_W.
  localparam int RCP_K  = WSUM_W + $clog2(WINDOW);
  localparam int RCP_W  = WSUM_W + 2;
  localparam int PROD_W = WSUM_W + RCP_W;
  localparam logic [RCP_W-1:0] RCP_M =
    RCP_W'(((64'd1 << RCP_K) + 64'(WINDOW - 1)) / 64'(WINDOW));

  logic [CNT_W-1:0]               cnt_r, cnt_nxt;
  logic signed [SUM_W-1:0]        sum_r, sum_nxt;
  logic signed [WSUM_W-1:0]       wsum_r, wsum_nxt;
  logic [PTR_W-1:0]               wptr_r, wptr_nxt;
  logic signed [SAMPLE_W-1:0]     win_r [WINDOW];
  logic                           acc_r, acc_nxt;
  logic signed [SAMPLE_W-1:0]     ovr_r, ovr_nxt;
  logic signed [SAMPLE_W-1:0]     rec_r, rec_nxt;
  logic                           ov_r, ov_nxt;
  logic                           oacc_r;
  logic [CNT_W-1:0]               ocnt_r;
  logic signed [SAMPLE_W-1:0]     oovr_r, orec_r;
  logic [WSUM_W-1:0]              wmag_r;
  logic                           wneg_r;
  logic [PROD_W-1:0]              wprod_r;
  logic                           wpneg_r;

  logic                           room;
  logic                           store;
  logic                           full_take;
  logic                           div_done;
  logic signed [SAMPLE_W-1:0]     div_q;
  logic [SAMPLE_W-1:0]            wquo;
  logic signed [SAMPLE_W-1:0]     win_q;

  assign room      = (cnt_r < CNT_W'(CAPACITY));
  assign store     = cmd.take && room;
  assign full_take = cmd.take && !room;

  always_comb begin
    cnt_nxt  = cnt_r;
    sum_nxt  = sum_r;
    wsum_nxt = wsum_r;
    wptr_nxt = wptr_r;
    acc_nxt  = acc_r;
    if (cmd.take) begin
      acc_nxt = room;
    end
    if (store) begin
      cnt_nxt  = cnt_r + 1'b1;
      sum_nxt  = sum_r + SUM_W'(in_sample);
      wsum_nxt = wsum_r + WSUM_W'(in_sample) - WSUM_W'(win_r[wptr_r]);
      wptr_nxt = (wptr_r == PTR_W'(WINDOW - 1)) ? '0 : wptr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      sum_r  <= '0;
      wsum_r <= '0;
      wptr_r <= '0;
      for (int i = 0; i < WINDOW; i++) begin
        win_r[i] <= '0;
      end
    end else begin
      cnt_r  <= cnt_nxt;
      sum_r  <= sum_nxt;
      wsum_r <= wsum_nxt;
      wptr_r <= wptr_nxt;
      if (store) begin
        win_r[wptr_r] <= in_sample;
      end
    end
    acc_r <= acc_nxt;
  end

  // Divider: running sum over count for the overall mean.
  ravg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (cmd.div_go),
    .dividend (sum_r),
    .divisor  (cnt_r),
    .done     (div_done),
    .quotient (div_q)
  );

  // Window mean: magnitude, then a registered 19 x 21 bit constant product;
  // both stages settle long before the division above finishes.
  always_ff @(posedge clk) begin
    wneg_r  <= wsum_r[WSUM_W-1];
    wmag_r  <= wsum_r[WSUM_W-1] ? WSUM_W'(~wsum_r + 1'b1) : $unsigned(wsum_r);
    wpneg_r <= wneg_r;
    wprod_r <= PROD_W'(wmag_r) * PROD_W'(RCP_M);
  end

  assign wquo  = wprod_r[RCP_K +: SAMPLE_W];
  assign win_q = wpneg_r ? $signed(~wquo + 1'b1) : $signed(wquo);

  always_comb begin
    ovr_nxt = ovr_r;
    rec_nxt = rec_r;
    if (cmd.ovr_zero) begin
      ovr_nxt = '0;
      rec_nxt = '0;
    end
    if (cmd.ovr_load) begin
      ovr_nxt = div_q;
    end
    if (cmd.rec_copy) begin
      rec_nxt = div_q;
    end
    if (cmd.rec_load) begin
      rec_nxt = win_q;
    end
  end

  always_ff @(posedge clk) begin
    ovr_r <= ovr_nxt;
    rec_r <= rec_nxt;
  end

  // Output register
  assign sts.out_free  = !ov_r || !out_stall;
  assign sts.cnt_zero  = (cnt_r == '0);
  assign sts.below_win = (cnt_r < CNT_W'(WINDOW));
  assign sts.div_done  = div_done;

  always_comb begin
    ov_nxt = ov_r;
    if (ov_r && !out_stall) begin
      ov_nxt = 1'b0;
    end
    if (cmd.out_load) begin
      ov_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
    end
    if (cmd.out_load) begin
      oacc_r <= acc_r;
      ocnt_r <= cnt_r;
      oovr_r <= ovr_r;
      orec_r <= rec_r;
    end
  end

  assign out_valid        = ov_r;
  assign out_accepted     = oacc_r;
  assign out_sample_total = ocnt_r;
  assign out_overall_mean = oovr_r;
  assign out_recent_mean  = orec_r;

  `RAVG_ASSERT_SAME(a_cnt_cap, 1'b1, cnt_r <= CNT_W'(CAPACITY), "count above capacity")
  `RAVG_ASSERT_NEXT(a_full_hold, full_take, $stable(cnt_r) && $stable(sum_r), "reject moved state")
  `RAVG_ASSERT_SAME(a_load_free, cmd.out_load, sts.out_free, "pending result overwritten")

endmodule

`default_nettype wire

>>> sv/ravg_ctrl.sv
// ----------------------------------------------------------------------------
// ravg_ctrl
// Sequencer: accept, run the division, hand the result to the output.
// ----------------------------------------------------------------------------
`default_nettype none
`include "running_and_window_average_core_defines.svh"

module ravg_ctrl
  import ravg_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire ravg_sts_t  sts,
  output ravg_cmd_t       cmd
);

  typedef enum logic [3:0] {
    S_IDLE    = 4'b0001,
    S_LAUNCH  = 4'b0010,
    S_DIV_OVR = 4'b0100,
    S_EMIT    = 4'b1000
  } ravg_state_t;

  ravg_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = S_LAUNCH;
        end
      end
      S_LAUNCH: begin
        if (sts.cnt_zero) begin
          cmd.ovr_zero = 1'b1;
          state_nxt    = S_EMIT;
        end else begin
          cmd.div_go = 1'b1;
          state_nxt  = S_DIV_OVR;
        end
      end
      S_DIV_OVR: begin
        if (sts.div_done) begin
          cmd.ovr_load = 1'b1;
          if (sts.below_win) begin
            cmd.rec_copy = 1'b1;
          end else begin
            cmd.rec_load = 1'b1;
          end
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `RAVG_ASSERT_SAME(a_done_state, sts.div_done, state_r == S_DIV_OVR, "stray quotient")

endmodule

`default_nettype wire

>>> verif/tb_running_and_window_average_core.sv
// ----------------------------------------------------------------------------
// tb_running_and_window_average_core
// Self-checking bench for the running and window average core. A driver
// offers Q8.8 temperatures from a queue, a predictor keeps its own count,
// sum and five-sample ring, and a monitor compares every result
// transaction field by field against the oldest expectation. Phases mix
// sender gaps and receiver stalls, include one long receiver hold-off,
// and run past capacity so that rejected samples are covered as well.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_running_and_window_average_core;
  timeunit 1ns;
  timeprecision 1ps;

  import ravg_pkg::*;

  localparam int CAPACITY    = 512;
  localparam int WINDOW      = 5;
  localparam int ITEMS_EACH  = 220;     // random transactions per phase
  localparam int LONG_HOLD   = 300;     // receiver hold-off, in cycles
  localparam int TAIL_CYCLES = 40;      // a full-window latency and a little more
  localparam int CYCLE_LIMIT = 500000;

  // One result transaction as the core presents it.
  typedef struct packed {
    logic                       accepted;
    logic [CNT_W-1:0]           sample_total;
    logic signed [SAMPLE_W-1:0] overall_mean;
    logic signed [SAMPLE_W-1:0] recent_mean;
  } mean_result_t;

  // Clock, reset and DUT ports; every input starts at a known value.
  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] in_sample = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic                       out_accepted;
  logic [CNT_W-1:0]           out_sample_total;
  logic signed [SAMPLE_W-1:0] out_overall_mean;
  logic signed [SAMPLE_W-1:0] out_recent_mean;

  // Stimulus and expectation stores.
  logic signed [SAMPLE_W-1:0] pending_temps[$];
  mean_result_t               expected_means[$];

  // Predictor state: mirrors the core's count, sum and recent-sample ring.
  int                         held_count = 0;
  longint                     sum_acc = 0;
  logic signed [SAMPLE_W-1:0] recent_ring[WINDOW];

  // Idling controls, set per phase by the stimulus process.
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  // Long hold-off: the stimulus process raises a request, the hold process
  // serves it by counting cycles on its own.
  int unsigned hold_requests = 0;
  int unsigned hold_served   = 0;
  int unsigned hold_left     = 0;

  // Bookkeeping.
  int unsigned mismatches   = 0;
  int unsigned results_seen = 0;
  int unsigned kept_seen    = 0;
  int unsigned dropped_seen = 0;
  int unsigned cycle_count  = 0;

  running_and_window_average_core #(
    .CAPACITY (CAPACITY),
    .WINDOW   (WINDOW)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sample        (in_sample),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_accepted     (out_accepted),
    .out_sample_total (out_sample_total),
    .out_overall_mean (out_overall_mean),
    .out_recent_mean  (out_recent_mean)
  );

  // 4 ns period, starting low.
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Advance the predictor by one accepted temperature and return the result
  // the core must report for it. Integer division in SystemVerilog truncates
  // toward zero, which is the rounding the core uses for both means.
  function automatic mean_result_t predict_means(logic signed [SAMPLE_W-1:0] temp);
    mean_result_t r;
    longint       overall;
    longint       ring_sum;
    r.accepted = 1'b0;
    overall    = 0;
    ring_sum   = 0;
    // Store only while below capacity; once full, leave the state alone.
    if (held_count < CAPACITY) begin
      recent_ring[held_count % WINDOW] = temp;
      sum_acc    += temp;
      held_count += 1;
      r.accepted  = 1'b1;
    end
    if (held_count != 0)
      overall = sum_acc / held_count;
    r.sample_total = CNT_W'(held_count);
    r.overall_mean = SAMPLE_W'(overall);
    // With a partial window, the recent mean falls back to the overall one.
    if (held_count >= WINDOW) begin
      for (int i = 0; i < WINDOW; i++)
        ring_sum += recent_ring[i];
      r.recent_mean = SAMPLE_W'(ring_sum / WINDOW);
    end else begin
      r.recent_mean = SAMPLE_W'(overall);
    end
    return r;
  endfunction

  // Draw a temperature: some rail and near-zero values, many readings
  // between -10 and +10 degrees, and the rest across the full range
  // so that every bit of the sample toggles.
  function automatic logic signed [SAMPLE_W-1:0] pick_temperature();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 10) begin
      case ($urandom_range(4))
        0:       return 16'sh7FFF;
        1:       return 16'sh8000;
        2:       return 16'sh0000;
        3:       return 16'shFFFF;
        default: return 16'sh0001;
      endcase
    end else if (sel < 50) begin
      return SAMPLE_W'($urandom_range(5120) - 2560);
    end
    return SAMPLE_W'($urandom);
  endfunction

  task automatic check_field(string field, longint want, longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, field, want, got);
      mismatches++;
    end
  endtask

  task automatic fill_random(int n);
    for (int i = 0; i < n; i++)
      pending_temps.push_back(pick_temperature());
  endtask

  // Hold until every queued temperature has been taken and every expected
  // result has come back.
  task automatic drain();
    while (pending_temps.size() != 0 || in_valid || expected_means.size() != 0)
      @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Driver: keep a stalled transaction steady; otherwise either go idle or
  // present the next temperature. Predict at the edge that accepts.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      in_sample <= '0;
    end else begin
      if (in_valid && !in_stall)
        expected_means.push_back(predict_means(in_sample));
      if (!in_valid || !in_stall) begin
        if (pending_temps.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid  <= 1'b1;
          in_sample <= pending_temps.pop_front();
        end else begin
          in_valid  <= 1'b0;
        end
      end
    end
  end

  // Count down a long hold-off whenever one has been requested.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      hold_left   <= LONG_HOLD;
      hold_served <= hold_served + 1;
    end
  end

  // Receiver back-pressure: forced during a hold-off, random otherwise.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= (hold_left > 1) || ($urandom_range(99) < recv_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: compare each accepted result against the oldest expectation.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    mean_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_means.size() == 0) begin
        $display("%0t: unexpected result transaction, accepted %0d total %0d overall %0d recent %0d",
                 $realtime, out_accepted, out_sample_total, out_overall_mean,
                 out_recent_mean);
        mismatches++;
      end else begin
        want = expected_means.pop_front();
        check_field("accepted", want.accepted, out_accepted);
        check_field("sample_total", want.sample_total, out_sample_total);
        check_field("overall_mean", want.overall_mean, out_overall_mean);
        check_field("recent_mean", want.recent_mean, out_recent_mean);
        results_seen++;
        if (want.accepted)
          kept_seen++;
        else
          dropped_seen++;
      end
    end
  end

  // Watchdog: end the run if it hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $realtime,
               expected_means.size());
      $display("tb_running_and_window_average_core NOT OK");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus sequence.
  // --------------------------------------------------------------------------
  initial begin
    for (int i = 0; i < WINDOW; i++)
      recent_ring[i] = '0;

    // Hold reset low from the start, then release it at a rising edge.
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: rails while the window is still filling, then full windows
    // of each rail, then small negatives where truncation toward zero
    // matters, then alternating bit patterns.
    pending_temps = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF,
                      16'sh0001,
                      16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                      16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                      -16'sd3, -16'sd4, 16'sd2, 16'sd7, -16'sd1,
                      16'sh5555, 16'shAAAA};
    drain();

    // Random, no idling; partway in, the receiver holds off for a long
    // stretch while the sender keeps offering, so the core backs up.
    fill_random(ITEMS_EACH);
    repeat (20) @(posedge clk);
    hold_requests++;
    drain();

    // Random, sender mostly idle.
    send_idle_pct = 81;
    fill_random(ITEMS_EACH);
    drain();

    // Random, receiver mostly stalling; capacity is passed in this phase.
    send_idle_pct  = 0;
    recv_stall_pct = 81;
    fill_random(ITEMS_EACH);
    drain();

    // Random, both sides idling lightly; everything here is rejected.
    send_idle_pct  = 9;
    recv_stall_pct = 9;
    fill_random(ITEMS_EACH);
    drain();

    // Let any stray result surface before the verdict.
    recv_stall_pct = 0;
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_means.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $realtime,
               expected_means.size());
      mismatches++;
    end

    $display("Checked %0d results: %0d samples stored, %0d rejected at capacity.",
             results_seen, kept_seen, dropped_seen);
    $display({"Phases: directed rails, no idling with a long hold-off, sender gaps, ",
              "receiver stalls, light idling on both sides."});
    if (mismatches == 0) begin
      $display("tb_running_and_window_average_core OK");
    end else begin
      $display("tb_running_and_window_average_core NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> filelist.f
+incdir+sv
sv/ravg_pkg.sv
sv/ravg_div.sv
sv/ravg_dp.sv
sv/ravg_ctrl.sv
sv/running_and_window_average_core.sv
verif/tb_running_and_window_average_core.sv
